@@ rtl/gppt_pkg.sv @@
// ============================================================================
// gppt_pkg
// Shared types and codes of the guest page permission table.
// ============================================================================
package gppt_pkg;

  // configuration register widths
  localparam int CFG_DATA_W = 64;
  localparam int HPS_W      = 3;

  // page entry layout: committed flag over read/write/execute bits
  localparam int ST_W         = 4;
  localparam int ACC_W        = 3;
  localparam int ST_COMMITTED = 3;

  // request modes
  typedef enum logic [2:0] {
    MODE_COMMIT    = 3'd0,
    MODE_PROTECT   = 3'd1,
    MODE_DECOMMIT  = 3'd2,
    MODE_QUERY     = 3'd3,
    MODE_TRANSLATE = 3'd4
  } mode_e;

  // host commands
  typedef enum logic [1:0] {
    HOP_NONE     = 2'd0,
    HOP_COMMIT   = 2'd1,
    HOP_PROTECT  = 2'd2,
    HOP_DECOMMIT = 2'd3
  } hop_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_WINDOW_BASE     = 1'b0,
    CFG_HOST_PAGE_SHIFT = 1'b1
  } cfg_idx_e;

  // request payload
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] page;
    logic [7:0]  access;
    logic [31:0] guest_address;
    logic [31:0] length;
    logic        host_accepts;
  } req_t;

  // result payload
  typedef struct packed {
    logic        ok;
    logic [1:0]  host_op;
    logic [63:0] host_address;
    logic [2:0]  host_access;
    logic [2:0]  page_access;
    logic [63:0] translated_address;
  } rsp_t;

endpackage

@@ rtl/gppt_chan_if.sv @@
// ============================================================================
// gppt_chan_if
// Valid/ready channel carrying one payload of type T.
// ============================================================================
interface gppt_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ rtl/gppt_store.sv @@
// ============================================================================
// gppt_store
// Page entry memory: one write port, one read port, registered read data.
// ============================================================================
module gppt_store #(
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [gppt_pkg::ST_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [gppt_pkg::ST_W-1:0] rdata_o
);

  logic [gppt_pkg::ST_W-1:0] mem [DEPTH];
  logic [gppt_pkg::ST_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gppt_ctrl.sv @@
// ============================================================================
// gppt_ctrl
// Sequencer: clears the store after reset, checks request arguments, walks
// the page entries of a host span, a queried page or a translate range through the
// store read port, and forms the result and the entry write-back.
// ============================================================================
module gppt_ctrl #(
  parameter int PAGE_COUNT     = 1024,
  parameter int PAGE_BITS      = 12,
  parameter int MAX_SPAN_SHIFT = 4,
  localparam int PW            = $clog2(PAGE_COUNT)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gppt_chan_if.sink                 req_i,
  input  logic [63:0]               window_base_i,
  input  logic [gppt_pkg::HPS_W-1:0] host_page_shift_i,
  input  logic                      slot_free_i,
  output logic                      res_valid_o,
  output gppt_pkg::rsp_t            res_o,
  output logic                      mem_we_o,
  output logic [PW-1:0]             mem_waddr_o,
  output logic [gppt_pkg::ST_W-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [PW-1:0]             mem_raddr_o,
  input  logic [gppt_pkg::ST_W-1:0] mem_rdata_i
);

  localparam int          EW         = PW + 9;
  localparam logic [63:0] WBYTES     = 64'(PAGE_COUNT) << PAGE_BITS;
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);
  localparam logic [31:0] PAGE_LIMIT = 32'(PAGE_COUNT);
  localparam logic [3:0]  MAX_SH     = 4'(MAX_SPAN_SHIFT);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [PW-1:0]                   clr_q, clr_d;
  logic                            rd_pend_q, rd_pend_d;
  logic                            rd_page_q, rd_page_d;
  gppt_pkg::req_t                  req_q, req_d;
  logic [32:0]                     sum_q, sum_d;
  logic [PW-1:0]                   c_q, c_d;
  logic [PW-1:0]                   last_q, last_d;
  logic [PW-1:0]                   first_q, first_d;
  logic                            fail_q, fail_d;
  logic [gppt_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic                            any_q, any_d;
  logic [gppt_pkg::ST_W-1:0]       cur_q, cur_d;
  logic                            good_q, good_d;

  logic [3:0]                      sh;
  logic [PW-1:0]                   page_idx;
  logic [PW-1:0]                   first;
  logic [EW-1:0]                   span_mask;
  logic [EW-1:0]                   span_end;
  logic [PW-1:0]                   last_span;
  logic                            in_table;
  logic                            acc_legal;
  logic                            acc_nz;
  logic                            range_ok;
  logic [32:0]                     end_byte;
  logic [PW-1:0]                   tr_first;
  logic [PW-1:0]                   tr_last;
  logic                            scan_go;
  logic [PW-1:0]                   scan_start;
  logic [PW-1:0]                   scan_last;
  logic [gppt_pkg::ACC_W-1:0]      req_acc;
  logic [63:0]                     add_b;
  logic [63:0]                     addr_sum;
  logic                            wr_go;
  logic [gppt_pkg::ST_W-1:0]       repl;
  gppt_pkg::rsp_t                  res;

  // span geometry
  always_comb begin
    sh        = ({1'b0, host_page_shift_i} > MAX_SH) ? MAX_SH : {1'b0, host_page_shift_i};
    page_idx  = req_q.page[PW-1:0];
    first     = (page_idx >> sh) << sh;
    span_mask = (EW'(1) << sh) - EW'(1);
    span_end  = EW'(first) + span_mask;
    last_span = (span_end > EW'(LAST_PAGE)) ? LAST_PAGE : span_end[PW-1:0];
  end

  // argument checks
  always_comb begin
    req_acc   = req_q.access[gppt_pkg::ACC_W-1:0];
    in_table  = req_q.page < PAGE_LIMIT;
    acc_legal = req_q.access[7:gppt_pkg::ACC_W] == '0;
    acc_nz    = req_acc != '0;
    range_ok  = (req_q.length != '0) && (64'(sum_q) <= WBYTES);
    end_byte  = sum_q - 33'd1;
    tr_first  = PW'(req_q.guest_address >> PAGE_BITS);
    tr_last   = PW'(end_byte >> PAGE_BITS);
  end

  // scan range per mode
  always_comb begin
    scan_go    = 1'b0;
    scan_start = first;
    scan_last  = last_span;
    case (gppt_pkg::mode_e'(req_q.mode))
      gppt_pkg::MODE_COMMIT:    scan_go = in_table && acc_legal && acc_nz;
      gppt_pkg::MODE_PROTECT:   scan_go = in_table && acc_legal;
      gppt_pkg::MODE_DECOMMIT:  scan_go = in_table;
      gppt_pkg::MODE_QUERY: begin
        scan_go    = in_table;
        scan_start = page_idx;
        scan_last  = page_idx;
      end
      gppt_pkg::MODE_TRANSLATE: begin
        scan_go    = acc_legal && acc_nz && range_ok;
        scan_start = tr_first;
        scan_last  = tr_last;
      end
      default:                  scan_go = 1'b0;
    endcase
  end

  // shared adder for host span and translated addresses
  always_comb begin
    if (gppt_pkg::mode_e'(req_q.mode) == gppt_pkg::MODE_TRANSLATE) begin
      add_b = {32'd0, req_q.guest_address};
    end else begin
      add_b = 64'(first_q) << PAGE_BITS;
    end
    addr_sum = window_base_i + add_b;
  end

  // result and write-back entry
  always_comb begin
    res   = '0;
    wr_go = 1'b0;
    repl  = '0;
    if (!fail_q) begin
      case (gppt_pkg::mode_e'(req_q.mode))
        gppt_pkg::MODE_COMMIT: begin
          res.host_op      = (any_q || cur_q[gppt_pkg::ST_COMMITTED]) ?
                             gppt_pkg::HOP_PROTECT : gppt_pkg::HOP_COMMIT;
          res.host_access  = acc_q | req_acc;
          res.host_address = addr_sum;
          res.ok           = req_q.host_accepts;
          wr_go            = req_q.host_accepts;
          repl             = {1'b1, req_acc};
        end
        gppt_pkg::MODE_PROTECT: begin
          if (cur_q[gppt_pkg::ST_COMMITTED]) begin
            res.host_op      = gppt_pkg::HOP_PROTECT;
            res.host_access  = acc_q | req_acc;
            res.host_address = addr_sum;
            res.ok           = req_q.host_accepts;
            wr_go            = req_q.host_accepts;
            repl             = {1'b1, req_acc};
          end
        end
        gppt_pkg::MODE_DECOMMIT: begin
          if (cur_q[gppt_pkg::ST_COMMITTED]) begin
            res.host_op      = any_q ? gppt_pkg::HOP_PROTECT : gppt_pkg::HOP_DECOMMIT;
            res.host_access  = acc_q;
            res.host_address = addr_sum;
            res.ok           = req_q.host_accepts;
            wr_go            = req_q.host_accepts;
          end
        end
        gppt_pkg::MODE_QUERY: begin
          res.ok          = cur_q[gppt_pkg::ST_COMMITTED];
          res.page_access = cur_q[gppt_pkg::ACC_W-1:0];
        end
        gppt_pkg::MODE_TRANSLATE: begin
          if (good_q) begin
            res.ok                 = 1'b1;
            res.translated_address = addr_sum;
          end
        end
        default: res = '0;
      endcase
    end
  end

  // sequencer and scan accumulation
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rd_pend_d   = 1'b0;
    rd_page_d   = rd_page_q;
    req_d       = req_q;
    sum_d       = sum_q;
    c_d         = c_q;
    last_d      = last_q;
    first_d     = first_q;
    fail_d      = fail_q;
    acc_d       = acc_q;
    any_d       = any_q;
    cur_d       = cur_q;
    good_d      = good_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = page_idx;
    mem_wdata_o = repl;
    mem_re_o    = 1'b0;
    mem_raddr_o = c_q;
    res_valid_o = 1'b0;

    // fold in the entry read last cycle
    if (rd_pend_q) begin
      if (rd_page_q) begin
        cur_d = mem_rdata_i;
      end else if (mem_rdata_i[gppt_pkg::ST_COMMITTED]) begin
        any_d = 1'b1;
        acc_d = acc_q | mem_rdata_i[gppt_pkg::ACC_W-1:0];
      end
      good_d = good_q && mem_rdata_i[gppt_pkg::ST_COMMITTED] &&
               ((mem_rdata_i[gppt_pkg::ACC_W-1:0] & req_acc) == req_acc);
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        if (clr_q == LAST_PAGE) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + PW'(1);
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.payload;
          sum_d   = {1'b0, req_i.payload.guest_address} + {1'b0, req_i.payload.length};
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        first_d = first;
        fail_d  = !scan_go;
        c_d     = scan_start;
        last_d  = scan_last;
        acc_d   = '0;
        any_d   = 1'b0;
        cur_d   = '0;
        good_d  = 1'b1;
        state_d = scan_go ? ST_SCAN : ST_RESULT;
      end
      ST_SCAN: begin
        mem_re_o  = 1'b1;
        rd_pend_d = 1'b1;
        rd_page_d = (c_q == page_idx);
        if (c_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          c_d = c_q + PW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free_i) begin
          res_valid_o = 1'b1;
          mem_we_o    = wr_go;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign res_o       = res;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    rd_page_q <= rd_page_d;
    req_q     <= req_d;
    sum_q     <= sum_d;
    c_q       <= c_d;
    last_q    <= last_d;
    first_q   <= first_d;
    fail_q    <= fail_d;
    acc_q     <= acc_d;
    any_q     <= any_d;
    cur_q     <= cur_d;
    good_q    <= good_d;
  end

endmodule

@@ rtl/guest_page_permission_table.sv @@
// ============================================================================
// guest_page_permission_table
// Committed flag and read/write/execute bits per guest page, with host span
// commands for commit, protect and decommit, page query and range translate.
// ============================================================================
//
// channel   dir  handshake            payload
// req_i     in   valid/ready          gppt_pkg::req_t (mode, page, access, ...)
// rsp_o     out  valid/ready          gppt_pkg::rsp_t (ok, host_op, ...)
// cfg       in   cfg_we_i, no stall   cfg_idx_i selects register, cfg_data_i
//
// One request at a time: accept, check, one store read per page, drain and
// result, in that order; the reads cover the pages of the host span (at most
// 2^MAX_SPAN_SHIFT), the pages a translate range touches, or 1 for query.
// Failed argument checks skip the reads; the single store read port serves them.
// After reset a clearing pass writes all PAGE_COUNT entries, one per cycle,
// before the first request; a result waits in the output register on stall.
//
module guest_page_permission_table #(
  parameter int PAGE_COUNT     = 1024,
  parameter int PAGE_BITS      = 12,
  parameter int MAX_SPAN_SHIFT = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gppt_chan_if.sink                      req_i,
  gppt_chan_if.source                    rsp_o,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [gppt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW = $clog2(PAGE_COUNT);

  logic [63:0]                window_base_q;
  logic [gppt_pkg::HPS_W-1:0] hps_q;
  logic                       out_valid_q, out_valid_d;
  gppt_pkg::rsp_t             out_q;
  logic                       slot_free;
  logic                       res_valid;
  gppt_pkg::rsp_t             res;
  logic                       mem_we;
  logic [PW-1:0]              mem_waddr;
  logic [gppt_pkg::ST_W-1:0]  mem_wdata;
  logic                       mem_re;
  logic [PW-1:0]              mem_raddr;
  logic [gppt_pkg::ST_W-1:0]  mem_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_base_q <= '0;
      hps_q         <= '0;
    end else if (cfg_we_i) begin
      case (gppt_pkg::cfg_idx_e'(cfg_idx_i))
        gppt_pkg::CFG_WINDOW_BASE:     window_base_q <= cfg_data_i;
        gppt_pkg::CFG_HOST_PAGE_SHIFT: hps_q         <= cfg_data_i[gppt_pkg::HPS_W-1:0];
        default:                       hps_q         <= hps_q;
      endcase
    end
  end

  // sequencer
  gppt_ctrl #(
    .PAGE_COUNT     (PAGE_COUNT),
    .PAGE_BITS      (PAGE_BITS),
    .MAX_SPAN_SHIFT (MAX_SPAN_SHIFT)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req_i),
    .window_base_i     (window_base_q),
    .host_page_shift_i (hps_q),
    .slot_free_i       (slot_free),
    .res_valid_o       (res_valid),
    .res_o             (res),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_re_o          (mem_re),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

  // page entry store
  gppt_store #(
    .DEPTH (PAGE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign slot_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // no host span is reported without a host command
  a_no_span_without_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.payload.host_op == gppt_pkg::HOP_NONE) |->
      (rsp_o.payload.host_address == '0) && (rsp_o.payload.host_access == '0))
    else $error("host span reported without host command");

  // a translated address only comes with success
  a_translate_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.payload.translated_address != '0) |-> rsp_o.payload.ok)
    else $error("translated address on failed request");

  // query results carry no host command
  a_query_no_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.payload.page_access != '0) |->
      (rsp_o.payload.host_op == gppt_pkg::HOP_NONE))
    else $error("page access reported with host command");

  // one request in flight: no accept right after an accept
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another is in flight");

endmodule

@@ test/guest_page_permission_table_checker.sv @@
// ============================================================================
// guest_page_permission_table_checker
// Watches the request, result and register channels of the page table,
// keeps its own copy of the page entries and registers, works out the result
// of every accepted request and compares it field by field, in order.
// ============================================================================
module guest_page_permission_table_checker #(
  parameter int PAGE_COUNT     = 1024,
  parameter int PAGE_BITS      = 12,
  parameter int MAX_SPAN_SHIFT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  gppt_pkg::req_t                  req_payload_i,
  input  logic                            rsp_valid_i,
  input  logic                            rsp_ready_i,
  input  gppt_pkg::rsp_t                  rsp_payload_i,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [gppt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     pending_o,
  output int unsigned                     fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored page entries and registers
  logic [gppt_pkg::ST_W-1:0]  page_state [PAGE_COUNT];
  logic [63:0]                window_base;
  logic [gppt_pkg::HPS_W-1:0] span_cfg;

  gppt_pkg::rsp_t permission_results_q [$];
  int unsigned    mismatches = 0;

  // pages per host span as a shift, clipped at the largest span
  function automatic int unsigned span_shift();
    return (span_cfg > MAX_SPAN_SHIFT) ? MAX_SPAN_SHIFT : int'(span_cfg);
  endfunction

  // OR of the access bits of committed span pages, with pg seen as entry
  function automatic logic [gppt_pkg::ACC_W-1:0] span_access(int unsigned pg,
      logic [gppt_pkg::ST_W-1:0] entry, output bit any_committed);
    int unsigned first;
    int unsigned c;
    logic [gppt_pkg::ST_W-1:0] st;
    logic [gppt_pkg::ACC_W-1:0] acc;
    first = (pg >> span_shift()) << span_shift();
    acc = '0;
    any_committed = 1'b0;
    for (int unsigned i = 0; i < (1 << span_shift()); i++) begin
      c = first + i;
      if (c < PAGE_COUNT) begin
        st = (c == pg) ? entry : page_state[c];
        if (st[gppt_pkg::ST_COMMITTED]) begin
          any_committed = 1'b1;
          acc |= st[gppt_pkg::ACC_W-1:0];
        end
      end
    end
    return acc;
  endfunction

  // expected result of one request; updates the mirrored entries
  function automatic gppt_pkg::rsp_t predict_permissions(gppt_pkg::req_t r);
    gppt_pkg::rsp_t res;
    logic [gppt_pkg::ST_W-1:0] cur;
    logic [gppt_pkg::ST_W-1:0] next_entry;
    logic [63:0] range_end;
    int unsigned pg;
    int unsigned first_page;
    int unsigned last_page;
    bit in_table;
    bit well_formed;
    bit any_committed;
    bit host_cmd;
    bit granted;
    res = '0;
    next_entry = '0;
    host_cmd = 1'b0;
    in_table = r.page < PAGE_COUNT;
    pg = in_table ? int'(r.page) : 0;
    well_formed = (r.access[7:gppt_pkg::ACC_W] == '0);
    cur = page_state[pg];
    case (r.mode)
      gppt_pkg::MODE_COMMIT: begin
        if (in_table && well_formed && r.access != '0) begin
          next_entry = {1'b1, r.access[gppt_pkg::ACC_W-1:0]};
          res.host_access = span_access(pg, next_entry, any_committed);
          void'(span_access(pg, cur, any_committed));
          res.host_op = any_committed ? gppt_pkg::HOP_PROTECT : gppt_pkg::HOP_COMMIT;
          host_cmd = 1'b1;
        end
      end
      gppt_pkg::MODE_PROTECT: begin
        if (in_table && well_formed && cur[gppt_pkg::ST_COMMITTED]) begin
          next_entry = {1'b1, r.access[gppt_pkg::ACC_W-1:0]};
          res.host_access = span_access(pg, next_entry, any_committed);
          res.host_op = gppt_pkg::HOP_PROTECT;
          host_cmd = 1'b1;
        end
      end
      gppt_pkg::MODE_DECOMMIT: begin
        if (in_table && cur[gppt_pkg::ST_COMMITTED]) begin
          res.host_access = span_access(pg, '0, any_committed);
          res.host_op = any_committed ? gppt_pkg::HOP_PROTECT : gppt_pkg::HOP_DECOMMIT;
          host_cmd = 1'b1;
        end
      end
      gppt_pkg::MODE_QUERY: begin
        if (in_table) begin
          res.ok = cur[gppt_pkg::ST_COMMITTED];
          res.page_access = cur[gppt_pkg::ACC_W-1:0];
        end
      end
      gppt_pkg::MODE_TRANSLATE: begin
        range_end = 64'(r.guest_address) + 64'(r.length);
        if (well_formed && r.access != '0 && r.length != '0 &&
            range_end <= (64'(PAGE_COUNT) << PAGE_BITS)) begin
          granted = 1'b1;
          first_page = r.guest_address >> PAGE_BITS;
          last_page = int'((range_end - 1) >> PAGE_BITS);
          for (int unsigned p = first_page; p <= last_page; p++) begin
            if (!page_state[p][gppt_pkg::ST_COMMITTED] ||
                (page_state[p][gppt_pkg::ACC_W-1:0] & r.access[gppt_pkg::ACC_W-1:0]) !=
                r.access[gppt_pkg::ACC_W-1:0])
              granted = 1'b0;
          end
          if (granted) begin
            res.ok = 1'b1;
            res.translated_address = window_base + 64'(r.guest_address);
          end
        end
      end
      default: ;
    endcase
    // host command issued: entry changes only when the host takes it
    if (host_cmd) begin
      res.host_address = window_base + (64'((pg >> span_shift()) << span_shift()) << PAGE_BITS);
      if (r.host_accepts) begin
        page_state[pg] = next_entry;
        res.ok = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // monitor: registers, requests, results
  always @(posedge clk_i or negedge rst_ni) begin
    gppt_pkg::rsp_t want;
    if (!rst_ni) begin
      foreach (page_state[i]) page_state[i] = '0;
      window_base = '0;
      span_cfg = '0;
      permission_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == gppt_pkg::CFG_WINDOW_BASE) window_base = cfg_data_i;
        else span_cfg = cfg_data_i[gppt_pkg::HPS_W-1:0];
      end
      if (req_valid_i && req_ready_i)
        permission_results_q.push_back(predict_permissions(req_payload_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (permission_results_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = permission_results_q.pop_front();
          check_field("ok", 64'(want.ok), 64'(rsp_payload_i.ok));
          check_field("host_op", 64'(want.host_op), 64'(rsp_payload_i.host_op));
          check_field("host_address", want.host_address, rsp_payload_i.host_address);
          check_field("host_access", 64'(want.host_access), 64'(rsp_payload_i.host_access));
          check_field("page_access", 64'(want.page_access), 64'(rsp_payload_i.page_access));
          check_field("translated_address", want.translated_address,
                      rsp_payload_i.translated_address);
        end
      end
      pending_o <= permission_results_q.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

@@ test/guest_page_permission_table_tb.sv @@
// ============================================================================
// guest_page_permission_table_tb
// Drives the page table with a directed set of commit, protect, decommit,
// query and translate requests, then random requests over several window
// base and host page shift settings, with random stalls on both channels outside the last phase.
// ============================================================================
module guest_page_permission_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_COUNT     = 1024;
  localparam int PAGE_BITS      = 12;
  localparam int MAX_SPAN_SHIFT = 4;
  localparam int PAGE_SIZE      = 1 << PAGE_BITS;
  localparam int HOT_PAGES      = 32;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 110;
  localparam int QUIET_LIMIT    = 8000;
  localparam int DRAIN_CYCLES   = 50;

  // modes the block does not know
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  gppt_pkg::cfg_idx_e cfg_idx;
  logic [gppt_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned pending;
  int unsigned fail_count;
  bit idle_on = 1'b1;
  int unsigned hot_base;

  gppt_chan_if #(.T(gppt_pkg::req_t)) req_ch ();
  gppt_chan_if #(.T(gppt_pkg::rsp_t)) rsp_ch ();

  guest_page_permission_table #(
    .PAGE_COUNT    (PAGE_COUNT),
    .PAGE_BITS     (PAGE_BITS),
    .MAX_SPAN_SHIFT(MAX_SPAN_SHIFT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_o     (rsp_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  guest_page_permission_table_checker #(
    .PAGE_COUNT    (PAGE_COUNT),
    .PAGE_BITS     (PAGE_BITS),
    .MAX_SPAN_SHIFT(MAX_SPAN_SHIFT)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_ch.valid),
    .req_ready_i  (req_ch.ready),
    .req_payload_i(req_ch.payload),
    .rsp_valid_i  (rsp_ch.valid),
    .rsp_ready_i  (rsp_ch.ready),
    .rsp_payload_i(rsp_ch.payload),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: ready with random stall bursts
  initial begin
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles in a row with no handshake on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("guest_page_permission_table_tb failed");
    $finish;
  end

  task automatic write_register(gppt_pkg::cfg_idx_e idx,
                                logic [gppt_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // present one request and hold it until taken; valid stays up afterwards
  task automatic send_request(gppt_pkg::req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic gppt_pkg::req_t make_request(logic [2:0] mode, logic [31:0] page,
      logic [7:0] access, logic [31:0] gaddr, logic [31:0] len, logic accepts);
    gppt_pkg::req_t r;
    r.mode = mode;
    r.page = page;
    r.access = access;
    r.guest_address = gaddr;
    r.length = len;
    r.host_accepts = accepts;
    return r;
  endfunction

  // random request, mostly on a small group of pages so entries get reused
  function automatic gppt_pkg::req_t roll_request();
    gppt_pkg::req_t r;
    int unsigned pick;
    r = make_request(3'($urandom), $urandom, 8'($urandom), $urandom, $urandom,
                     1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 30) r.mode = gppt_pkg::MODE_COMMIT;
    else if (pick < 45) r.mode = gppt_pkg::MODE_PROTECT;
    else if (pick < 60) r.mode = gppt_pkg::MODE_DECOMMIT;
    else if (pick < 73) r.mode = gppt_pkg::MODE_QUERY;
    else if (pick < 95) r.mode = gppt_pkg::MODE_TRANSLATE;
    else r.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    // page number
    pick = $urandom_range(0, 99);
    if (pick < 70) r.page = hot_base + $urandom_range(0, HOT_PAGES - 1);
    else if (pick < 80) r.page = $urandom_range(0, PAGE_COUNT - 1);
    else if (pick < 88) r.page = PAGE_COUNT - 4 + $urandom_range(0, 7);
    // access bits
    pick = $urandom_range(0, 99);
    if (pick < 80) r.access = 8'($urandom_range(1, 7));
    else if (pick < 88) r.access = '0;
    r.host_accepts = ($urandom_range(0, 9) != 0);
    // translate range
    if ($urandom_range(0, 99) < 85)
      r.guest_address = (hot_base << PAGE_BITS) + $urandom_range(0, HOT_PAGES * PAGE_SIZE - 1);
    pick = $urandom_range(0, 99);
    if (pick < 60) r.length = $urandom_range(1, PAGE_SIZE);
    else if (pick < 88) r.length = $urandom_range(1, 3 * PAGE_SIZE);
    else if (pick < 92) r.length = '0;
    else if (pick < 94) begin
      r.guest_address = '0;
      r.length = PAGE_COUNT * PAGE_SIZE;
    end
    return r;
  endfunction

  // shift per phase, the clipped values among them
  logic [gppt_pkg::HPS_W-1:0] shift_plan [PHASES] =
    '{3'd0, 3'd4, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3};

  // stimulus and verdict
  initial begin
    gppt_pkg::req_t directed_q [$];
    logic [gppt_pkg::CFG_DATA_W-1:0] base;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= gppt_pkg::CFG_WINDOW_BASE;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: span of four pages around pages 5 and 6
    write_register(gppt_pkg::CFG_WINDOW_BASE, 64'h0000_0040_0000_0000);
    write_register(gppt_pkg::CFG_HOST_PAGE_SHIFT, 64'd2);
    directed_q.push_back(make_request(gppt_pkg::MODE_QUERY, 0, 8'h0, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_COMMIT, 5, 8'h7, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_COMMIT, 6, 8'h1, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_COMMIT, 7, 8'h08, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_COMMIT, 8, 8'h0, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_COMMIT, PAGE_COUNT - 1, 8'h2, 0, 0,
                                      1'b0));
    directed_q.push_back(make_request(gppt_pkg::MODE_COMMIT, PAGE_COUNT, 8'h1, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_COMMIT, 32'hFFFF_FFFF, 8'h7, 0, 0,
                                      1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_PROTECT, 6, 8'h4, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_PROTECT, 9, 8'h1, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_PROTECT, 5, 8'h80, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_QUERY, 5, 8'h0, 0, 0, 1'b0));
    directed_q.push_back(make_request(gppt_pkg::MODE_QUERY, 32'hFFFF_FFFF, 8'hFF, 0, 0,
                                      1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_TRANSLATE, 0, 8'h4, 5 * PAGE_SIZE,
                                      2 * PAGE_SIZE, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_TRANSLATE, 0, 8'h1, 5 * PAGE_SIZE,
                                      2 * PAGE_SIZE, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_TRANSLATE, 0, 8'h4, 5 * PAGE_SIZE, 0,
                                      1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_TRANSLATE, 0, 8'h7, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 1'b0));
    directed_q.push_back(make_request(gppt_pkg::MODE_TRANSLATE, 0, 8'hFC, 5 * PAGE_SIZE + 1,
                                      1, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_TRANSLATE, 0, 8'h0, 5 * PAGE_SIZE + 1,
                                      1, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_TRANSLATE, 0, 8'h1,
                                      PAGE_COUNT * PAGE_SIZE - 1, 1, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_DECOMMIT, 6, 8'h0, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_DECOMMIT, 5, 8'h0, 0, 0, 1'b0));
    directed_q.push_back(make_request(gppt_pkg::MODE_DECOMMIT, 5, 8'h0, 0, 0, 1'b1));
    directed_q.push_back(make_request(gppt_pkg::MODE_DECOMMIT, 9, 8'h0, 0, 0, 1'b1));
    directed_q.push_back(make_request(MODE_UNUSED_LO, 5, 8'h7, 0, 4, 1'b1));
    directed_q.push_back(make_request(MODE_UNUSED_HI, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 1'b1));
    foreach (directed_q[i]) send_request(directed_q[i]);
    wait_drained();

    // random phases, each with its own window base and span size
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) base = '0;
      else if (p == 1) base = '1;
      else if (p == 2) base = 64'h8000_0000_0000_0000;
      else base = {$urandom, $urandom};
      hot_base = (p == 3) ? PAGE_COUNT - HOT_PAGES : $urandom_range(0, PAGE_COUNT - HOT_PAGES);
      write_register(gppt_pkg::CFG_WINDOW_BASE, base);
      write_register(gppt_pkg::CFG_HOST_PAGE_SHIFT, 64'(shift_plan[p]));
      idle_on = (p != PHASES - 1);
      repeat (PHASE_ITEMS) send_request(roll_request());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("guest_page_permission_table_tb passed");
    else $display("guest_page_permission_table_tb failed");
    $finish;
  end

endmodule
